// ===== sv/mat_pkg.sv =====
package mat_pkg;

	localparam int SLOTS = 8;
	localparam int TICK_BITS = 32;
	localparam int SLOT_IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef logic [TICK_BITS-1:0] tick_t;
	typedef logic [SLOT_IW-1:0] slot_idx_t;

	typedef enum logic [1:0] {
		OP_SET     = 2'd0,
		OP_CLEAR   = 2'd1,
		OP_SERVICE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		KIND_FIRED = 2'd0,
		KIND_ALARM = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	typedef struct packed {
		op_t       op;
		logic      ok;
		slot_idx_t idx;
		tick_t     dl_new;
		tick_t     now;
	} cmd_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  fired_slot;
		logic [31:0] next_delay;
		logic        rejected;
		logic        last;
	} res_t;

	function automatic tick_t to_tick(input logic [31:0] v);
		logic [TICK_BITS+31:0] w;
		w = {{TICK_BITS{1'b0}}, v};
		return w[TICK_BITS-1:0];
	endfunction

	function automatic logic [31:0] to_word(input tick_t v);
		logic [TICK_BITS+31:0] w;
		w = {32'b0, v};
		return w[31:0];
	endfunction

endpackage

// ===== sv/mat_front.sv =====
module mat_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  logic [1:0]     operation,
	input  logic [7:0]     slot,
	input  logic [31:0]    delay_ticks,
	input  logic           handler_valid,
	input  logic [31:0]    now,
	output logic           cmd_valid,
	output mat_pkg::cmd_t  cmd_head,
	input  logic           cmd_pop
);

	mat_pkg::cmd_t q_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;
	mat_pkg::cmd_t cmd_in;
	logic          known_op;
	logic          in_range;
	logic          wr_en;

	assign in_range = {1'b0, slot} < 9'(mat_pkg::SLOTS);

	always_comb begin
		cmd_in.idx    = slot[mat_pkg::SLOT_IW-1:0];
		cmd_in.now    = mat_pkg::to_tick(now);
		cmd_in.dl_new = mat_pkg::to_tick(now) + mat_pkg::to_tick(delay_ticks);
		cmd_in.op     = mat_pkg::OP_SERVICE;
		cmd_in.ok     = 1'b1;
		known_op      = 1'b1;
		case (operation)
			mat_pkg::OP_SET: begin
				cmd_in.op = mat_pkg::OP_SET;
				cmd_in.ok = in_range && handler_valid;
			end
			mat_pkg::OP_CLEAR: begin
				cmd_in.op = mat_pkg::OP_CLEAR;
				cmd_in.ok = in_range;
			end
			mat_pkg::OP_SERVICE: begin
				cmd_in.op = mat_pkg::OP_SERVICE;
			end
			default: begin
				known_op = 1'b0;
			end
		endcase
	end

	assign full      = (cnt_q == 2'd2);
	assign wr_en     = push && !full && known_op;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd_head  = q_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) wr_q <= !wr_q;
			if (cmd_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(wr_en) - 2'(cmd_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) q_q[wr_q] <= cmd_in;
	end

endmodule

// ===== sv/mat_res_queue.sv =====
module mat_res_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          res_push,
	input  mat_pkg::res_t res_word,
	output logic          res_full,
	output logic          empty,
	input  logic          pop,
	output mat_pkg::res_t head
);

	mat_pkg::res_t q_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;
	logic          rd_en;

	assign res_full = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign rd_en    = pop && !empty;
	assign head     = q_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (res_push) wr_q <= !wr_q;
			if (rd_en) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(res_push) - 2'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) q_q[wr_q] <= res_word;
	end

endmodule

// ===== sv/mat_back.sv =====
module mat_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	input  logic [31:0]   cfg_data,
	input  logic          cmd_valid,
	input  mat_pkg::cmd_t cmd_head,
	output logic          cmd_pop,
	output logic          res_push,
	output mat_pkg::res_t res_word,
	input  logic          res_full
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t             state_q;
	mat_pkg::tick_t     deadline_q [mat_pkg::SLOTS];
	mat_pkg::tick_t     alarm_dl_q;
	logic               armed_q;
	logic [31:0]        period_q;
	mat_pkg::cmd_t      cmd_q;
	mat_pkg::tick_t     reload_q;
	mat_pkg::slot_idx_t idx_q;

	mat_pkg::tick_t cur;
	mat_pkg::tick_t diff;
	mat_pkg::tick_t remain;
	logic           cur_live;
	logic           expire;
	logic           step;
	logic           scan_end;
	logic           running;

	assign cur      = deadline_q[idx_q];
	assign cur_live = (cur != '0);
	assign diff     = cur - cmd_q.now;
	assign expire   = (cmd_q.op == mat_pkg::OP_SERVICE) && cur_live && (cur <= cmd_q.now);
	assign step     = (state_q == ST_SCAN) && (!expire || !res_full);
	assign scan_end = (idx_q == mat_pkg::SLOT_IW'(mat_pkg::SLOTS - 1));

	assign remain  = alarm_dl_q - cmd_head.now;
	assign running = armed_q && (remain != '0) && !remain[mat_pkg::TICK_BITS-1];

	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;

	always_comb begin
		res_push            = 1'b0;
		res_word.kind       = mat_pkg::KIND_ALARM;
		res_word.fired_slot = 8'd0;
		res_word.next_delay = 32'd0;
		res_word.rejected   = 1'b0;
		res_word.last       = 1'b1;
		case (state_q)
			ST_SCAN: begin
				res_word.kind       = mat_pkg::KIND_FIRED;
				res_word.fired_slot = 8'(idx_q);
				res_word.last       = 1'b0;
				res_push            = expire && !res_full;
			end
			ST_DONE: begin
				res_push          = !res_full;
				res_word.rejected = !cmd_q.ok;
				if (cmd_q.op == mat_pkg::OP_CLEAR) begin
					res_word.kind = mat_pkg::KIND_CLEAR;
				end else begin
					res_word.next_delay = mat_pkg::to_word(reload_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			alarm_dl_q <= '0;
			armed_q    <= 1'b0;
			period_q   <= 32'd100;
			for (int i = 0; i < mat_pkg::SLOTS; i++) deadline_q[i] <= '0;
		end else begin
			if (cfg_valid) period_q <= cfg_data;
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						idx_q <= '0;
						if (cmd_head.op == mat_pkg::OP_SET && cmd_head.ok)
							deadline_q[cmd_head.idx] <= cmd_head.dl_new;
						if (cmd_head.op == mat_pkg::OP_CLEAR) begin
							if (cmd_head.ok) deadline_q[cmd_head.idx] <= '0;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (step) begin
						if (expire) deadline_q[idx_q] <= '0;
						if (scan_end) state_q <= ST_DONE;
						else idx_q <= idx_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (!res_full) begin
						if (cmd_q.op != mat_pkg::OP_CLEAR) begin
							alarm_dl_q <= cmd_q.now + reload_q;
							armed_q    <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q    <= cmd_head;
			reload_q <= running ? remain : mat_pkg::to_tick(period_q);
		end else if (step && !expire && cur_live && (diff < reload_q)) begin
			reload_q <= diff;
		end
	end

endmodule

// ===== sv/multi_slot_alarm_table.sv =====
// Alarm table with one-shot alarm reload search.
// Fired words appear as the slot scan reaches them; the final word of a set or service
// follows the scan, while a clear skips the scan and goes straight to its final word.
// Set and service scan one slot per cycle unless a fired word meets a full result queue;
// a two-word command queue decouples input from the scan.
// Reset (arst_n low): table idle, alarm disarmed, default_period 100, queues empty.
module multi_slot_alarm_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  operation,
	input  logic [7:0]  slot,
	input  logic [31:0] delay_ticks,
	input  logic        handler_valid,
	input  logic [31:0] now,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [7:0]  fired_slot,
	output logic [31:0] next_delay,
	output logic        rejected,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	mat_pkg::cmd_t cmd_head;
	logic          cmd_valid;
	logic          cmd_pop;
	mat_pkg::res_t res_word;
	mat_pkg::res_t head;
	logic          res_push;
	logic          res_full;

	assign cfg_ready = 1'b1;

	mat_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.operation     (operation),
		.slot          (slot),
		.delay_ticks   (delay_ticks),
		.handler_valid (handler_valid),
		.now           (now),
		.cmd_valid     (cmd_valid),
		.cmd_head      (cmd_head),
		.cmd_pop       (cmd_pop)
	);

	mat_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_head  (cmd_head),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res_word  (res_word),
		.res_full  (res_full)
	);

	mat_res_queue u_res (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_word (res_word),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.head     (head)
	);

	assign kind       = head.kind;
	assign fired_slot = head.fired_slot;
	assign next_delay = head.next_delay;
	assign rejected   = head.rejected;
	assign last       = head.last;

endmodule

// ===== sv/mat_checker.sv =====
module mat_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [1:0]  kind,
	input logic [7:0]  fired_slot,
	input logic [31:0] next_delay,
	input logic        rejected,
	input logic        last
);

	a_fired_word: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == mat_pkg::KIND_FIRED) |->
		(!last && !rejected && next_delay == 32'd0 &&
		 {1'b0, fired_slot} < 9'(mat_pkg::SLOTS)))
		else $error("fired word malformed");

	a_final_words: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (kind == mat_pkg::KIND_ALARM || kind == mat_pkg::KIND_CLEAR)) |->
		(last && fired_slot == 8'd0))
		else $error("alarm or clear word not last");

	a_clear_word: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == mat_pkg::KIND_CLEAR) |-> (next_delay == 32'd0))
		else $error("clear word carries a delay");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(kind) && $stable(fired_slot) &&
		 $stable(next_delay) && $stable(last)))
		else $error("stalled result word changed");

endmodule

bind multi_slot_alarm_table mat_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.kind       (kind),
	.fired_slot (fired_slot),
	.next_delay (next_delay),
	.rejected   (rejected),
	.last       (last)
);

// ===== tb/alarm_table_monitor.sv =====
module alarm_table_monitor
	import mat_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [1:0]  operation,
	input  logic [7:0]  slot,
	input  logic [31:0] delay_ticks,
	input  logic        handler_valid,
	input  logic [31:0] now,
	input  logic        empty,
	input  logic        pop,
	input  logic [1:0]  kind,
	input  logic [7:0]  fired_slot,
	input  logic [31:0] next_delay,
	input  logic        rejected,
	input  logic        last,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output int          mismatches,
	output int          outstanding,
	output int          fired_words
);

	tick_t       deadlines [SLOTS];
	tick_t       alarm_at;
	logic        alarm_armed;
	logic [31:0] period;
	res_t        owed_words [$];
	int          n_bad;
	int          n_fired;

	// remaining time of a running alarm, else the period, lowered to the nearest deadline
	function automatic tick_t alarm_reload(input tick_t t);
		tick_t best;
		tick_t gap;
		gap = alarm_at - t;
		if (alarm_armed && gap != '0 && !gap[TICK_BITS-1])
			best = gap;
		else
			best = tick_t'(period);
		for (int i = 0; i < SLOTS; i++) begin
			gap = deadlines[i] - t;
			if (deadlines[i] != '0 && gap < best)
				best = gap;
		end
		return best;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		res_t  got;
		res_t  want;
		tick_t r;
		logic  rej;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++)
				deadlines[i] = '0;
			alarm_at = '0;
			alarm_armed = 1'b0;
			period = 32'd100;
			owed_words.delete();
			n_bad = 0;
			n_fired = 0;
		end else begin
			if (pop && !empty) begin
				got = '{kind_t'(kind), fired_slot, next_delay, rejected, last};
				if (owed_words.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("unexpected word: kind=%0d slot=%0d delay=%0d rej=%0d last=%0d",
							got.kind, got.fired_slot, got.next_delay, got.rejected,
							got.last);
				end else begin
					want = owed_words.pop_front();
					if (got.kind !== want.kind || got.fired_slot !== want.fired_slot ||
							got.next_delay !== want.next_delay ||
							got.rejected !== want.rejected || got.last !== want.last) begin
						n_bad++;
						if (n_bad <= 10)
							$display({"word mismatch: exp kind=%0d slot=%0d delay=%0d rej=%0d ",
								"last=%0d, got kind=%0d slot=%0d delay=%0d rej=%0d last=%0d"},
								want.kind, want.fired_slot, want.next_delay, want.rejected,
								want.last, got.kind, got.fired_slot, got.next_delay,
								got.rejected, got.last);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				period = cfg_data;
			if (push && !full) begin
				case (operation)
					OP_SET: begin
						rej = !(slot < SLOTS && handler_valid);
						if (!rej)
							deadlines[slot[SLOT_IW-1:0]] = tick_t'(now) + tick_t'(delay_ticks);
						r = alarm_reload(tick_t'(now));
						alarm_at = tick_t'(now) + r;
						alarm_armed = 1'b1;
						owed_words.push_back('{KIND_ALARM, 8'd0, 32'(r), rej, 1'b1});
					end
					OP_CLEAR: begin
						rej = !(slot < SLOTS);
						if (!rej)
							deadlines[slot[SLOT_IW-1:0]] = '0;
						owed_words.push_back('{KIND_CLEAR, 8'd0, 32'd0, rej, 1'b1});
					end
					OP_SERVICE: begin
						for (int i = 0; i < SLOTS; i++) begin
							if (deadlines[i] != '0 && deadlines[i] <= tick_t'(now)) begin
								deadlines[i] = '0;
								n_fired++;
								owed_words.push_back('{KIND_FIRED, 8'(i), 32'd0, 1'b0, 1'b0});
							end
						end
						r = alarm_reload(tick_t'(now));
						alarm_at = tick_t'(now) + r;
						alarm_armed = 1'b1;
						owed_words.push_back('{KIND_ALARM, 8'd0, 32'(r), 1'b0, 1'b1});
					end
					default: ;
				endcase
			end
		end
		mismatches <= n_bad;
		outstanding <= owed_words.size();
		fired_words <= n_fired;
	end

endmodule

// ===== tb/tb_multi_slot_alarm_table.sv =====
module tb_multi_slot_alarm_table;
	import mat_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE = 24;
	localparam int PHASE_WORDS = 70;
	localparam logic [1:0] OP_UNKNOWN = 2'd3;

	typedef enum int {POP_ALWAYS, POP_HALF, POP_SLOW} pop_mode_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [1:0]  operation;
	logic [7:0]  slot;
	logic [31:0] delay_ticks;
	logic        handler_valid;
	logic [31:0] now;
	logic        empty;
	logic        pop;
	logic [1:0]  kind;
	logic [7:0]  fired_slot;
	logic [31:0] next_delay;
	logic        rejected;
	logic        last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;

	int    mismatches;
	int    outstanding;
	int    fired_words;
	int    idle_cycles;
	int    sent;
	int    period_writes;
	int    burst_left;
	tick_t tick_now;

	multi_slot_alarm_table dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.operation(operation), .slot(slot), .delay_ticks(delay_ticks),
		.handler_valid(handler_valid), .now(now),
		.empty(empty), .pop(pop),
		.kind(kind), .fired_slot(fired_slot), .next_delay(next_delay),
		.rejected(rejected), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	alarm_table_monitor monitor (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.operation(operation), .slot(slot), .delay_ticks(delay_ticks),
		.handler_valid(handler_valid), .now(now),
		.empty(empty), .pop(pop),
		.kind(kind), .fired_slot(fired_slot), .next_delay(next_delay),
		.rejected(rejected), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.mismatches(mismatches), .outstanding(outstanding), .fired_words(fired_words)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// result side: the pop pattern switches at random between always, half and slow modes
	initial begin : receiver
		pop_mode_t mode;
		int        span;
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			mode = pop_mode_t'($urandom_range(2));
			span = $urandom_range(10, 80);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					POP_ALWAYS: pop <= 1'b1;
					POP_HALF:   pop <= ($urandom_range(1) == 1);
					default:    pop <= ($urandom_range(7) == 0);
				endcase
			end
		end
	end

	task automatic send_word(input logic [1:0] op, input logic [7:0] s, input logic [31:0] d,
			input logic h, input logic [31:0] t);
		int gap;
		push <= 1'b1;
		operation <= op;
		slot <= s;
		delay_ticks <= d;
		handler_valid <= h;
		now <= t;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(8);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 60) : $urandom_range(12);
		end
	endtask

	// sender holds off until every expected word is back and the back end is quiet
	task automatic drain;
		push <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_period(input logic [31:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		period_writes++;
	endtask

	task automatic send_random;
		int          pick;
		logic [1:0]  op;
		logic [7:0]  s;
		logic [31:0] d;
		logic        h;
		pick = $urandom_range(99);
		if (pick < 45)
			op = OP_SET;
		else if (pick < 60)
			op = OP_CLEAR;
		else if (pick < 95)
			op = OP_SERVICE;
		else
			op = OP_UNKNOWN;
		s = 8'(($urandom_range(99) < 85) ? $urandom_range(SLOTS - 1) : $urandom_range(255));
		h = ($urandom_range(9) != 0);
		pick = $urandom_range(99);
		if (pick < 60)
			d = $urandom_range(300);
		else if (pick < 85)
			d = $urandom_range(5000);
		else
			d = $urandom();
		if ($urandom_range(99) < 3)
			tick_now = $urandom();
		else
			tick_now = tick_now + $urandom_range(60);
		send_word(op, s, d, h, tick_now);
	endtask

	initial begin : stimulus
		logic [31:0] periods [5];
		arst_n <= 1'b0;
		push <= 1'b0;
		operation <= OP_SET;
		slot <= 8'd0;
		delay_ticks <= 32'd0;
		handler_valid <= 1'b0;
		now <= 32'd0;
		cfg_valid <= 1'b0;
		cfg_data <= 32'd0;
		sent = 0;
		period_writes = 0;
		burst_left = $urandom_range(1, 12);
		tick_now = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset period
		send_word(OP_SERVICE, 8'd0, 32'd0, 1'b1, 32'd0);
		send_word(OP_SET, 8'd0, 32'd50, 1'b1, 32'd10);
		send_word(OP_SET, 8'd7, 32'hFFFF_FFFF, 1'b1, 32'd20);
		send_word(OP_SET, 8'd8, 32'd5, 1'b1, 32'd30);
		send_word(OP_SET, 8'd255, 32'd5, 1'b1, 32'd30);
		send_word(OP_SET, 8'd3, 32'd5, 1'b0, 32'd30);
		send_word(OP_SET, 8'd2, 32'hFFFF_FFF0, 1'b1, 32'h10);  // deadline wraps to zero
		send_word(OP_CLEAR, 8'd7, 32'd0, 1'b1, 32'd40);
		send_word(OP_CLEAR, 8'd255, 32'd0, 1'b1, 32'd40);
		send_word(OP_CLEAR, 8'd8, 32'd0, 1'b0, 32'd40);
		send_word(OP_SERVICE, 8'd0, 32'd0, 1'b1, 32'd100);
		send_word(OP_SET, 8'd4, 32'd0, 1'b1, 32'd200);  // zero reload
		send_word(OP_UNKNOWN, 8'd1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
		for (int i = 0; i < SLOTS; i++)
			send_word(OP_SET, 8'(i), 32'(i + 1), 1'b1, 32'h1000);
		send_word(OP_SERVICE, 8'd0, 32'd0, 1'b1, 32'hFFFF_FFFF);  // every slot fires
		send_word(OP_SERVICE, 8'd0, 32'd0, 1'b1, 32'h8000_0000);  // alarm long expired
		send_word(OP_SET, 8'd1, 32'h7FFF_FFFF, 1'b1, 32'd0);
		send_word(OP_CLEAR, 8'd1, 32'd0, 1'b1, 32'd0);

		periods[0] = 32'd1;
		periods[1] = 32'hFFFF_FFFF;
		periods[2] = $urandom_range(1, 400);
		periods[3] = 32'h8000_0000;
		periods[4] = 32'd37;
		foreach (periods[p]) begin
			write_period(periods[p]);
			repeat (PHASE_WORDS) send_random();
		end

		drain();
		$display("%0d commands over %0d default_period settings, %0d slot expiries seen",
			sent, period_writes, fired_words);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
